// ===== rtl/mbceb_pkg.sv =====
package mbceb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 49;
  localparam int BASE_W  = 48;
  localparam int PITCH_W = 16;
  localparam int PB_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 4;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic [0:0] CMD_START = 1'b0;
  localparam logic [0:0] CMD_DATA  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VALID = 2'd3;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd16384;
  localparam logic [PB_W-1:0]    PB_RESET    = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SUM_A = 5'b00100,
    ST_SUM_B = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

endpackage

// ===== rtl/mono_bitmap_color_expand_blit_core.sv =====
// Start word: accept, then multiply, then two passes through the shared adder.
// Data word: accept, then one pixel write per cycle while the output is not stalled, for up to 8 writes;
// each step of the 49-bit address goes through the one shared adder.
// The input is ready only in idle, so a new word waits until the previous word is fully processed.
// rst is synchronous, active high: no blit active, output empty, registers
// return to base 0, pitch 16384, 4 bytes per pixel, framebuffer invalid.
module mono_bitmap_color_expand_blit_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // origin_x, origin_y, fg_color, blit_width, blit_height, data_byte, zero pad
  input  logic [mbceb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // write_address, pixel_value, zero pad
  output logic [mbceb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                 m_axis_tlast,
  // blit_done
  output logic [0:0]                           m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbceb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbceb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbceb_pkg::*;

  state_t state;

  logic [BASE_W-1:0]  frame_base;
  logic [PITCH_W-1:0] line_pitch;
  logic [PB_W-1:0]    pixel_bytes;
  logic               frame_valid;

  logic                        active;
  logic [ADDR_W-1:0]           row_start;
  logic [ADDR_W-1:0]           next_address;
  logic [DIM_W-1:0]            rows_left;
  logic [DIM_W-1:0]            pixels_left;
  logic [DIM_W-1:0]            row_width;
  logic [COLOR_W-1:0]          fill_color;
  logic [COORD_W-1:0]          org_x;
  logic [COORD_W-1:0]          org_y;
  logic [COORD_W+PITCH_W-1:0]  prod_y;
  logic [COORD_W+PB_W-1:0]     prod_x;
  logic [RUN_W-1:0]            run_left;
  logic [BYTE_W-1:0]           bits;

  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_pixel;
  logic               out_last;
  logic               out_done;
  logic               out_valid;

  logic              in_acc;
  logic              step_ok;
  logic              step;
  logic              out_load;
  logic              run_end;
  logic              row_end;
  logic              row_change;
  logic              done_bit;
  logic [ADDR_W-1:0] add_a;
  logic [ADDR_W-1:0] add_b;
  logic [ADDR_W-1:0] add_sum;
  logic [DIM_W-1:0]  in_w;
  logic [DIM_W-1:0]  in_h;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = (state == ST_IDLE) && !s_axis_tvalid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_w = clamp_dim(s_axis_tdata[68:56]);
  assign in_h = clamp_dim(s_axis_tdata[81:69]);

  assign run_end    = (run_left == RUN_W'(1));
  assign row_end    = run_end && (pixels_left == DIM_W'(1));
  assign row_change = row_end && (rows_left != DIM_W'(1));
  assign done_bit   = row_end && (rows_left == DIM_W'(1));

  assign step_ok  = !frame_valid || !out_valid || m_axis_tready;
  assign step     = (state == ST_EMIT) && step_ok;
  assign out_load = step && frame_valid;

  // shared address adder
  always_comb begin
    case (state)
      ST_SUM_A: begin
        add_a = ADDR_W'(frame_base);
        add_b = ADDR_W'(prod_y);
      end
      ST_SUM_B: begin
        add_a = row_start;
        add_b = ADDR_W'(prod_x);
      end
      ST_EMIT: begin
        if (row_change) begin
          add_a = row_start;
          add_b = ADDR_W'(line_pitch);
        end else begin
          add_a = next_address;
          add_b = ADDR_W'(pixel_bytes);
        end
      end
      default: begin
        add_a = next_address;
        add_b = ADDR_W'(pixel_bytes);
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base  <= '0;
      line_pitch  <= PITCH_RESET;
      pixel_bytes <= PB_RESET;
      frame_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_BASE:  frame_base  <= cfg_data[BASE_W-1:0];
        REG_LINE_PITCH:  line_pitch  <= cfg_data[PITCH_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes <= cfg_data[PB_W-1:0];
        REG_FRAME_VALID: frame_valid <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == CMD_START) begin
              active <= frame_valid && (in_w != '0) && (in_h != '0);
              state  <= ST_MUL;
            end else if (active) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_MUL:   state <= ST_SUM_A;
        ST_SUM_A: state <= ST_SUM_B;
        ST_SUM_B: state <= ST_IDLE;
        ST_EMIT: begin
          if (step && run_end) begin
            state <= ST_IDLE;
            if (done_bit) begin
              active <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      if (s_axis_tuser == CMD_START) begin
        org_x       <= s_axis_tdata[11:0];
        org_y       <= s_axis_tdata[23:12];
        fill_color  <= s_axis_tdata[55:24];
        row_width   <= in_w;
        rows_left   <= in_h;
        pixels_left <= in_w;
      end else begin
        bits     <= s_axis_tdata[89:82];
        run_left <= (pixels_left < DIM_W'(8)) ? pixels_left[RUN_W-1:0] : RUN_W'(8);
      end
    end
    if (state == ST_MUL) begin
      prod_y <= (COORD_W+PITCH_W)'(org_y) * (COORD_W+PITCH_W)'(line_pitch);
      prod_x <= (COORD_W+PB_W)'(org_x) * (COORD_W+PB_W)'(pixel_bytes);
    end
    if (state == ST_SUM_A) begin
      row_start <= add_sum;
    end
    if (state == ST_SUM_B) begin
      row_start    <= add_sum;
      next_address <= add_sum;
    end
    if (step) begin
      bits        <= {bits[BYTE_W-2:0], 1'b0};
      run_left    <= run_left - RUN_W'(1);
      pixels_left <= row_change ? row_width : pixels_left - DIM_W'(1);
      next_address <= add_sum;
      if (row_end) begin
        rows_left <= rows_left - DIM_W'(1);
      end
      if (row_change) begin
        row_start <= add_sum;
      end
    end
    if (out_load) begin
      out_addr  <= next_address;
      out_pixel <= bits[BYTE_W-1] ? fill_color : '0;
      out_last  <= run_end;
      out_done  <= done_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_pixel, out_addr};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_done;

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("blit_done without last_of_run");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (run_left != '0 && run_left <= RUN_W'(8)))
    else $error("run length out of range");

  a_row_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (pixels_left != '0 && rows_left != '0 && active))
    else $error("emitting with no pixels left");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (step && done_bit) |=> (!active && state == ST_IDLE))
    else $error("blit still active after final write");

endmodule

// ===== bench/mono_bitmap_color_expand_blit_core_tb.sv =====
module mono_bitmap_color_expand_blit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbceb_pkg::*;

  typedef struct {
    logic [0:0]         kind;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COLOR_W-1:0] color;
    logic [DIM_W-1:0]   wd;
    logic [DIM_W-1:0]   ht;
    logic [BYTE_W-1:0]  bits;
    bit                 hold;
  } blit_word_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] value;
    logic               last;
    logic               done;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = CMD_START;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_FRAME_BASE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mono_bitmap_color_expand_blit_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  blit_word_t   blit_words_pending[$];
  pixel_write_t pixel_writes_due[$];
  blit_word_t   word_on_bus;
  int           gap_left = 0;
  int           stall_left = 0;
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  bit           quiet = 1'b0;
  int           mismatches = 0;
  int           words_queued = 0;

  // register copies
  logic [BASE_W-1:0]  fb_base = '0;
  logic [PITCH_W-1:0] fb_pitch = PITCH_RESET;
  logic [PB_W-1:0]    fb_step = PB_RESET;
  logic               fb_ok = 1'b0;

  // blit position tracking
  logic               blit_on = 1'b0;
  logic [ADDR_W-1:0]  row_addr = '0;
  logic [ADDR_W-1:0]  pix_addr = '0;
  logic [DIM_W-1:0]   rows_to_go = '0;
  logic [DIM_W-1:0]   cols_to_go = '0;
  logic [DIM_W-1:0]   span = '0;
  logic [COLOR_W-1:0] ink = '0;

  task automatic expand_word(input blit_word_t w);
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    int               n;
    bit               fin;
    pixel_write_t     pw;
    if (w.kind == CMD_START) begin
      sw = (w.wd > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : w.wd;
      sh = (w.ht > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : w.ht;
      ink = w.color;
      span = sw;
      rows_to_go = sh;
      cols_to_go = sw;
      row_addr = ADDR_W'(64'(fb_base) + 64'(w.oy) * 64'(fb_pitch)
                         + 64'(w.ox) * 64'(fb_step));
      pix_addr = row_addr;
      blit_on = fb_ok && sw != 0 && sh != 0;
      return;
    end
    if (!blit_on) return;
    n = (cols_to_go < 8) ? int'(cols_to_go) : 8;
    fin = (n == int'(cols_to_go)) && rows_to_go == 1;
    for (int i = 0; i < n; i++) begin
      if (fb_ok) begin
        pw.addr = pix_addr;
        pw.value = w.bits[7-i] ? ink : '0;
        pw.last = (i == n - 1);
        pw.done = (i == n - 1) && fin;
        pixel_writes_due.push_back(pw);
      end
      pix_addr = pix_addr + ADDR_W'(fb_step);
    end
    cols_to_go = cols_to_go - DIM_W'(n);
    if (cols_to_go == 0) begin
      rows_to_go = rows_to_go - 1'b1;
      if (rows_to_go == 0) begin
        blit_on = 1'b0;
      end else begin
        row_addr = row_addr + ADDR_W'(fb_pitch);
        pix_addr = row_addr;
        cols_to_go = span;
      end
    end
  endtask

  // bitmap word source
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expand_word(word_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (blit_words_pending.size() != 0 &&
                     (!blit_words_pending[0].hold || pixel_writes_due.size() == 0)) begin
          word_on_bus = blit_words_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= word_on_bus.kind;
          s_axis_tdata <= {6'b0, word_on_bus.bits, word_on_bus.ht, word_on_bus.wd,
                           word_on_bus.color, word_on_bus.oy, word_on_bus.ox};
          if (!quiet && $urandom_range(0, 99) < send_gap_pct)
            gap_left = $urandom_range(1, 6);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel write sink
  always @(posedge clk) begin
    pixel_write_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_writes_due.size() == 0) begin
          $error("unexpected pixel write, write_address %h", m_axis_tdata[ADDR_W-1:0]);
          mismatches++;
        end else begin
          want = pixel_writes_due.pop_front();
          if (m_axis_tdata[ADDR_W-1:0] !== want.addr) begin
            $error("write_address: expected %h, got %h", want.addr,
                   m_axis_tdata[ADDR_W-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[ADDR_W +: COLOR_W] !== want.value) begin
            $error("pixel_value: expected %h, got %h", want.value,
                   m_axis_tdata[ADDR_W +: COLOR_W]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser[0] !== want.done) begin
            $error("blit_done: expected %b, got %b", want.done, m_axis_tuser[0]);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < stall_pct)
          stall_left = $urandom_range(1, 6);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_BASE:  fb_base = val[BASE_W-1:0];
      REG_LINE_PITCH:  fb_pitch = val[PITCH_W-1:0];
      REG_PIXEL_BYTES: fb_step = val[PB_W-1:0];
      REG_FRAME_VALID: fb_ok = val[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [BASE_W-1:0] base, input logic [PITCH_W-1:0] pitch,
                           input logic [PB_W-1:0] step, input logic ok);
    write_reg(REG_FRAME_BASE, CFG_DATA_W'(base));
    write_reg(REG_LINE_PITCH, CFG_DATA_W'(pitch));
    write_reg(REG_PIXEL_BYTES, CFG_DATA_W'(step));
    write_reg(REG_FRAME_VALID, CFG_DATA_W'(ok));
  endtask

  // wait until the block has nothing left to do
  task automatic settle();
    while (blit_words_pending.size() != 0 || s_axis_tvalid || pixel_writes_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_start(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COLOR_W-1:0] color, input logic [DIM_W-1:0] wd,
                             input logic [DIM_W-1:0] ht);
    blit_word_t w;
    w.kind = CMD_START;
    w.ox = x;
    w.oy = y;
    w.color = color;
    w.wd = wd;
    w.ht = ht;
    w.bits = BYTE_W'($urandom);
    w.hold = ($urandom_range(0, 39) == 0);
    blit_words_pending.push_back(w);
    words_queued++;
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    blit_word_t w;
    w.kind = CMD_DATA;
    w.ox = COORD_W'($urandom);
    w.oy = COORD_W'($urandom);
    w.color = $urandom;
    w.wd = DIM_W'($urandom);
    w.ht = DIM_W'($urandom);
    w.bits = b;
    w.hold = ($urandom_range(0, 39) == 0);
    blit_words_pending.push_back(w);
    words_queued++;
  endtask

  task automatic random_blits(input int target);
    int goal;
    int wd;
    int ht;
    int total;
    int cut;
    int r;
    goal = words_queued + target;
    while (words_queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        wd = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        ht = $urandom_range(1, 3);
        total = ((wd + 7) / 8) * ht;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
        queue_start(COORD_W'($urandom), COORD_W'($urandom), $urandom, DIM_W'(wd), DIM_W'(ht));
        for (int i = 0; i < cut; i++) queue_byte(BYTE_W'($urandom));
        if ($urandom_range(0, 9) == 0) queue_byte(BYTE_W'($urandom));
      end else if (r < 90) begin
        queue_start(COORD_W'($urandom), COORD_W'($urandom), $urandom,
                    DIM_W'($urandom), DIM_W'($urandom));
        repeat ($urandom_range(0, 3)) queue_byte(BYTE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // framebuffer invalid after reset: nothing is written
    queue_start(12'd5, 12'd7, 32'h1234_5678, 13'd8, 13'd1);
    queue_byte(8'hFF);
    settle();
    set_frame(48'h1234_5678_9ABC, 16'd640, 3'd4, 1'b1);

    send_gap_pct = 20;
    stall_pct = 20;
    queue_start(12'd0, 12'd0, 32'hFFFF_FFFF, 13'd1, 13'd1);
    queue_byte(8'h80);
    queue_start(12'hFFF, 12'hFFF, 32'h0000_0000, 13'd8, 13'd1);
    queue_byte(8'hFF);
    queue_start(12'd9, 12'd9, 32'h1111_1111, 13'd0, 13'd5);
    queue_byte(8'hFF);
    queue_start(12'd9, 12'd9, 32'h2222_2222, 13'd5, 13'd0);
    queue_byte(8'hFF);
    queue_start(12'd3, 12'd2, 32'hA5A5_5A5A, 13'd13, 13'd2);
    queue_byte(8'hA5);
    queue_byte(8'hF8);
    queue_byte(8'h3C);
    queue_byte(8'hFF);
    // past the last row
    queue_byte(8'h55);
    // oversize, then abandoned by a new start
    queue_start(12'hFFF, 12'd0, 32'hDEAD_BEEF, 13'h1FFF, 13'h1FFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_start(12'd100, 12'd50, 32'h0F0F_F0F0, 13'd9, 13'd1);
    queue_byte(8'h01);
    queue_byte(8'h80);
    settle();

    // framebuffer turned off and registers changed in the middle of a blit
    queue_start(12'd20, 12'd30, 32'hCAFE_F00D, 13'd16, 13'd2);
    queue_byte(8'h96);
    settle();
    write_reg(REG_FRAME_VALID, CFG_DATA_W'(1'b0));
    queue_byte(8'hFF);
    queue_byte(8'h69);
    settle();
    write_reg(REG_FRAME_VALID, CFG_DATA_W'(1'b1));
    write_reg(REG_PIXEL_BYTES, CFG_DATA_W'(3'd2));
    write_reg(REG_LINE_PITCH, CFG_DATA_W'(16'd100));
    queue_byte(8'hC3);
    settle();

    set_frame(48'h0, 16'hFFFF, 3'd1, 1'b1);
    send_gap_pct = 25;
    stall_pct = 0;
    random_blits(60);
    settle();

    set_frame(48'hFFFF_FFFF_FFFF, 16'd0, 3'd4, 1'b1);
    send_gap_pct = 0;
    stall_pct = 30;
    random_blits(60);
    settle();

    set_frame(BASE_W'({$urandom, $urandom}), PITCH_W'($urandom), 3'd0, 1'b1);
    send_gap_pct = 15;
    stall_pct = 15;
    random_blits(40);
    settle();

    write_reg(REG_FRAME_VALID, CFG_DATA_W'(1'b0));
    random_blits(25);
    settle();

    set_frame(BASE_W'({$urandom, $urandom}), PITCH_W'($urandom), PB_W'($urandom_range(5, 7)),
              1'b1);
    send_gap_pct = 30;
    stall_pct = 30;
    random_blits(60);
    settle();

    set_frame(BASE_W'({$urandom, $urandom}), PITCH_W'($urandom), PB_W'($urandom_range(1, 4)),
              1'b1);
    quiet = 1'b1;
    random_blits(60);
    settle();

    if (pixel_writes_due.size() != 0) begin
      $error("%0d pixel writes never arrived", pixel_writes_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
